>>> design/pidbi_pkg.sv
package pidbi_pkg;

    localparam int MEAS_W     = 24;
    localparam int GAIN_W     = 16;
    localparam int GAIN_FRAC  = 8;
    localparam int BAND_W     = 24;
    localparam int INT_W      = 32;
    localparam int OUT_W      = 32;

    localparam int ERR_W      = MEAS_W + 1;
    localparam int DER_W      = ERR_W + 1;
    localparam int ACC_W      = ((ERR_W > INT_W) ? ERR_W : INT_W) + 1;
    localparam int CMP_W      = (ERR_W > BAND_W) ? ERR_W : BAND_W;
    localparam int PP_P_W     = ERR_W + GAIN_W + 1;
    localparam int PP_I_W     = INT_W + GAIN_W + 1;
    localparam int PP_D_W     = DER_W + GAIN_W + 1;
    localparam int SUM_W      = ((PP_D_W > PP_I_W) ? PP_D_W : PP_I_W) + 2;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = (MEAS_W > BAND_W) ? MEAS_W : BAND_W;

    localparam logic [CFG_IDX_W-1:0] REG_SETPOINT = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_P   = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_I   = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_D   = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] REG_BAND     = CFG_IDX_W'(4);

    localparam logic signed [INT_W-1:0] INT_MAX = {1'b0, {(INT_W-1){1'b1}}};
    localparam logic signed [INT_W-1:0] INT_MIN = {1'b1, {(INT_W-1){1'b0}}};
    localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

    typedef struct packed {
        logic signed [MEAS_W-1:0] setpoint;
        logic [GAIN_W-1:0]        gain_p;
        logic [GAIN_W-1:0]        gain_i;
        logic [GAIN_W-1:0]        gain_d;
        logic [BAND_W-1:0]        band;
    } cfg_t;

endpackage

>>> design/pidbi_meas_if.sv
interface pidbi_meas_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [pidbi_pkg::MEAS_W-1:0]   measured_value;

    modport source (output valid, output measured_value, input ready);
    modport sink   (input valid, input measured_value, output ready);
endinterface

>>> design/pidbi_drive_if.sv
interface pidbi_drive_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [pidbi_pkg::OUT_W-1:0]    drive_value;
    logic                                  saturated;

    modport source (output valid, output drive_value, output saturated, input ready);
    modport sink   (input valid, input drive_value, input saturated, output ready);
endinterface

>>> design/pidbi_cfg_if.sv
interface pidbi_cfg_if;
    logic                                  valid;
    logic                                  ready;
    logic [pidbi_pkg::CFG_IDX_W-1:0]       index;
    logic [pidbi_pkg::CFG_DATA_W-1:0]      data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

>>> design/pidbi_cfg_regs.sv
module pidbi_cfg_regs (
    input  logic               clk,
    input  logic               rst_n,
    pidbi_cfg_if.sink          regs,
    output pidbi_pkg::cfg_t    cfg
);

    pidbi_pkg::cfg_t cfg_reg;

    assign regs.ready = 1'b1;
    assign cfg        = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (regs.valid)
        begin
            case (regs.index)
                pidbi_pkg::REG_SETPOINT: cfg_reg.setpoint <= regs.data[pidbi_pkg::MEAS_W-1:0];
                pidbi_pkg::REG_GAIN_P:   cfg_reg.gain_p   <= regs.data[pidbi_pkg::GAIN_W-1:0];
                pidbi_pkg::REG_GAIN_I:   cfg_reg.gain_i   <= regs.data[pidbi_pkg::GAIN_W-1:0];
                pidbi_pkg::REG_GAIN_D:   cfg_reg.gain_d   <= regs.data[pidbi_pkg::GAIN_W-1:0];
                pidbi_pkg::REG_BAND:     cfg_reg.band     <= regs.data[pidbi_pkg::BAND_W-1:0];
                default:                 cfg_reg          <= cfg_reg;
            endcase
        end
    end

endmodule

>>> design/pidbi_err_stage.sv
module pidbi_err_stage (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  pidbi_pkg::cfg_t                       cfg,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic signed [pidbi_pkg::MEAS_W-1:0]   meas,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [pidbi_pkg::ERR_W-1:0]    err,
    output logic signed [pidbi_pkg::DER_W-1:0]    deriv,
    output logic signed [pidbi_pkg::INT_W-1:0]    integ
);

    logic                                  in_valid_reg;
    logic signed [pidbi_pkg::MEAS_W-1:0]   meas_reg;
    logic                                  st_valid_reg;
    // err_reg doubles as the previous error, integ_reg as the integral
    logic signed [pidbi_pkg::ERR_W-1:0]    err_reg;
    logic signed [pidbi_pkg::DER_W-1:0]    deriv_reg;
    logic signed [pidbi_pkg::INT_W-1:0]    integ_reg;

    logic                                  st_ready;
    logic                                  st_load;
    logic signed [pidbi_pkg::ERR_W-1:0]    err_next;
    logic signed [pidbi_pkg::DER_W-1:0]    deriv_next;
    logic signed [pidbi_pkg::INT_W-1:0]    integ_next;
    logic [pidbi_pkg::ERR_W-1:0]           err_mag;
    logic                                  in_band;
    logic signed [pidbi_pkg::ACC_W-1:0]    acc;
    logic signed [pidbi_pkg::INT_W-1:0]    acc_sat;
    logic                                  err_zero;
    logic                                  prev_zero;
    logic                                  sign_diff;

    assign st_ready  = !st_valid_reg || out_ready;
    assign in_ready  = !in_valid_reg || st_ready;
    assign st_load   = in_valid_reg && st_ready;
    assign out_valid = st_valid_reg;
    assign err       = err_reg;
    assign deriv     = deriv_reg;
    assign integ     = integ_reg;

    always_comb
    begin
        err_next   = {cfg.setpoint[pidbi_pkg::MEAS_W-1], cfg.setpoint}
                   - {meas_reg[pidbi_pkg::MEAS_W-1], meas_reg};
        deriv_next = {err_next[pidbi_pkg::ERR_W-1], err_next}
                   - {err_reg[pidbi_pkg::ERR_W-1], err_reg};
        err_mag    = err_next[pidbi_pkg::ERR_W-1] ? (~err_next + 1'b1) : err_next;
        in_band    = pidbi_pkg::CMP_W'(err_mag) < pidbi_pkg::CMP_W'(cfg.band);

        acc = pidbi_pkg::ACC_W'(integ_reg) + pidbi_pkg::ACC_W'(err_next);
        if (acc > pidbi_pkg::ACC_W'(pidbi_pkg::INT_MAX))
        begin
            acc_sat = pidbi_pkg::INT_MAX;
        end
        else if (acc < pidbi_pkg::ACC_W'(pidbi_pkg::INT_MIN))
        begin
            acc_sat = pidbi_pkg::INT_MIN;
        end
        else
        begin
            acc_sat = acc[pidbi_pkg::INT_W-1:0];
        end

        // sign is -1, 0 or +1: zero counts as a sign of its own
        err_zero  = (err_next == '0);
        prev_zero = (err_reg == '0);
        sign_diff = (err_zero != prev_zero)
                 || (!err_zero && (err_next[pidbi_pkg::ERR_W-1] != err_reg[pidbi_pkg::ERR_W-1]));

        integ_next = integ_reg;
        if (cfg.gain_i != '0)
        begin
            // clear wins over add
            if (sign_diff)
            begin
                integ_next = '0;
            end
            else if (in_band)
            begin
                integ_next = acc_sat;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            st_valid_reg <= 1'b0;
            err_reg      <= '0;
            integ_reg    <= '0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (st_ready)
            begin
                st_valid_reg <= in_valid_reg;
            end
            if (st_load)
            begin
                err_reg   <= err_next;
                integ_reg <= integ_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            meas_reg <= meas;
        end
        if (st_load)
        begin
            deriv_reg <= deriv_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        !st_load |=> ($stable(integ_reg) && $stable(err_reg)))
        else $error("loop state changed without a new sample");

    assert property (@(posedge clk) disable iff (!rst_n)
        (st_load && cfg.gain_i == '0) |=> $stable(integ_reg))
        else $error("integral moved while its gain is zero");

    assert property (@(posedge clk) disable iff (!rst_n)
        (st_load && cfg.gain_i != '0 && sign_diff) |=> (integ_reg == '0))
        else $error("integral not cleared on error sign change");

endmodule

>>> design/pidbi_mult_stage.sv
module pidbi_mult_stage (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  pidbi_pkg::cfg_t                       cfg,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic signed [pidbi_pkg::ERR_W-1:0]    err,
    input  logic signed [pidbi_pkg::DER_W-1:0]    deriv,
    input  logic signed [pidbi_pkg::INT_W-1:0]    integ,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [pidbi_pkg::PP_P_W-1:0]   pp_p,
    output logic signed [pidbi_pkg::PP_I_W-1:0]   pp_i,
    output logic signed [pidbi_pkg::PP_D_W-1:0]   pp_d
);

    logic                                  valid_reg;
    logic signed [pidbi_pkg::PP_P_W-1:0]   pp_p_reg;
    logic signed [pidbi_pkg::PP_I_W-1:0]   pp_i_reg;
    logic signed [pidbi_pkg::PP_D_W-1:0]   pp_d_reg;
    logic signed [pidbi_pkg::GAIN_W:0]     kp;
    logic signed [pidbi_pkg::GAIN_W:0]     ki;
    logic signed [pidbi_pkg::GAIN_W:0]     kd;

    // gains are unsigned: pad a zero sign bit
    assign kp        = {1'b0, cfg.gain_p};
    assign ki        = {1'b0, cfg.gain_i};
    assign kd        = {1'b0, cfg.gain_d};
    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign pp_p      = pp_p_reg;
    assign pp_i      = pp_i_reg;
    assign pp_d      = pp_d_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            pp_p_reg <= err * kp;
            pp_i_reg <= integ * ki;
            pp_d_reg <= deriv * kd;
        end
    end

endmodule

>>> design/pidbi_out_stage.sv
module pidbi_out_stage (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic signed [pidbi_pkg::PP_P_W-1:0]   pp_p,
    input  logic signed [pidbi_pkg::PP_I_W-1:0]   pp_i,
    input  logic signed [pidbi_pkg::PP_D_W-1:0]   pp_d,
    pidbi_drive_if.source                         result
);

    logic                                  valid_reg;
    logic signed [pidbi_pkg::OUT_W-1:0]    drive_reg;
    logic                                  sat_reg;
    logic signed [pidbi_pkg::SUM_W-1:0]    sum;
    logic signed [pidbi_pkg::SUM_W-1:0]    shifted;
    logic signed [pidbi_pkg::OUT_W-1:0]    drive_next;
    logic                                  sat_next;

    assign in_ready           = !valid_reg || result.ready;
    assign result.valid       = valid_reg;
    assign result.drive_value = drive_reg;
    assign result.saturated   = sat_reg;

    always_comb
    begin
        sum = pidbi_pkg::SUM_W'(pp_p) + pidbi_pkg::SUM_W'(pp_i) + pidbi_pkg::SUM_W'(pp_d);
        // drop the gain fraction, rounding toward minus infinity
        shifted = sum >>> pidbi_pkg::GAIN_FRAC;
        if (shifted > pidbi_pkg::SUM_W'(pidbi_pkg::OUT_MAX))
        begin
            drive_next = pidbi_pkg::OUT_MAX;
            sat_next   = 1'b1;
        end
        else if (shifted < pidbi_pkg::SUM_W'(pidbi_pkg::OUT_MIN))
        begin
            drive_next = pidbi_pkg::OUT_MIN;
            sat_next   = 1'b1;
        end
        else
        begin
            drive_next = shifted[pidbi_pkg::OUT_W-1:0];
            sat_next   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            drive_reg <= drive_next;
            sat_reg   <= sat_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && sat_reg)
            |-> (drive_reg == pidbi_pkg::OUT_MAX || drive_reg == pidbi_pkg::OUT_MIN))
        else $error("saturation flag set on an unclipped drive word");

endmodule

>>> design/pid_with_banded_integral.sv
// PID controller with a banded, sign-reset integral.
// Channels: sample (sink) takes one measured_value word per sample; result
// (source) gives one drive_value/saturated word per sample, in order; regs
// (sink) writes a register by index: 0 setpoint, 1 gain_p, 2 gain_i,
// 3 gain_d, 4 integral_band. regs.ready is always high; unknown indexes are
// dropped. Write registers only while no sample is in flight.
// Path: an accepted sample lands in the input register, then passes the
// error/integral, multiplier and sum/clamp stage registers in that order.
// Throughput: one sample per cycle while result is not stalled; the previous
// error and integral are updated in the same load that takes each sample,
// which lets samples follow back to back.
// Reset: the config registers, previous error and integral go to zero and
// the pipeline empties.
// Stall: each stage holds while the one after it is full and stalled, so a
// stalled receiver keeps the result word steady and up to four samples stay
// buffered; sample.ready drops only when all stages are full.
module pid_with_banded_integral (
    input  logic            clk,
    input  logic            rst_n,
    pidbi_meas_if.sink      sample,
    pidbi_drive_if.source   result,
    pidbi_cfg_if.sink       regs
);

    pidbi_pkg::cfg_t                       cfg;
    logic                                  e_valid;
    logic                                  e_ready;
    logic signed [pidbi_pkg::ERR_W-1:0]    err;
    logic signed [pidbi_pkg::DER_W-1:0]    deriv;
    logic signed [pidbi_pkg::INT_W-1:0]    integ;
    logic                                  m_valid;
    logic                                  m_ready;
    logic signed [pidbi_pkg::PP_P_W-1:0]   pp_p;
    logic signed [pidbi_pkg::PP_I_W-1:0]   pp_i;
    logic signed [pidbi_pkg::PP_D_W-1:0]   pp_d;

    pidbi_cfg_regs u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .regs  (regs),
        .cfg   (cfg)
    );

    pidbi_err_stage u_err (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (sample.valid),
        .in_ready  (sample.ready),
        .meas      (sample.measured_value),
        .out_valid (e_valid),
        .out_ready (e_ready),
        .err       (err),
        .deriv     (deriv),
        .integ     (integ)
    );

    pidbi_mult_stage u_mult (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (e_valid),
        .in_ready  (e_ready),
        .err       (err),
        .deriv     (deriv),
        .integ     (integ),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .pp_p      (pp_p),
        .pp_i      (pp_i),
        .pp_d      (pp_d)
    );

    pidbi_out_stage u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (m_valid),
        .in_ready (m_ready),
        .pp_p     (pp_p),
        .pp_i     (pp_i),
        .pp_d     (pp_d),
        .result   (result)
    );

endmodule

>>> test/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import pidbi_pkg::*;

    localparam longint MEAS_HI  = (longint'(1) <<< (MEAS_W - 1)) - 1;
    localparam longint MEAS_LO  = -(longint'(1) <<< (MEAS_W - 1));
    localparam int     GAIN_MAX = (1 << GAIN_W) - 1;
    localparam int     BAND_MAX = (1 << BAND_W) - 1;
    localparam int     IDX_TOP  = (1 << CFG_IDX_W) - 1;

    typedef struct {
        logic signed [OUT_W-1:0] drive_value;
        logic                    saturated;
    } drive_word_t;

    logic clk;
    logic rst_n;
    bit   quiet;
    int   fail_count;

    // loop state and register copies
    longint sp_reg, kp_reg, ki_reg, kd_reg, band_reg;
    longint last_err, integ;

    drive_word_t drive_due[$];
    drive_word_t want_word;

    pidbi_meas_if  sample_ch();
    pidbi_drive_if result_ch();
    pidbi_cfg_if   regs_ch();

    pid_with_banded_integral dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample_ch),
        .result (result_ch),
        .regs   (regs_ch)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #1_000_000;
        $display("pid_with_banded_integral: mismatch");
        $finish;
    end

    function automatic int sign3(longint v);
        return (v > 0) ? 1 : ((v < 0) ? -1 : 0);
    endfunction

    function automatic drive_word_t drive_for_sample(logic signed [MEAS_W-1:0] meas);
        longint      err, slope, mag, total, drv;
        drive_word_t w;
        err   = sp_reg - meas;
        slope = err - last_err;
        if (ki_reg != 0)
        begin
            mag = (err < 0) ? -err : err;
            if (mag < band_reg)
            begin
                integ = integ + err;
                if (integ > INT_MAX)
                    integ = INT_MAX;
                if (integ < INT_MIN)
                    integ = INT_MIN;
            end
            // sign change clears, even after an add
            if (sign3(err) != sign3(last_err))
                integ = 0;
        end
        total = err * kp_reg + integ * ki_reg + slope * kd_reg;
        drv   = total >>> GAIN_FRAC;
        w.saturated = 1'b0;
        if (drv > OUT_MAX)
        begin
            drv = OUT_MAX;
            w.saturated = 1'b1;
        end
        if (drv < OUT_MIN)
        begin
            drv = OUT_MIN;
            w.saturated = 1'b1;
        end
        w.drive_value = drv[OUT_W-1:0];
        last_err = err;
        return w;
    endfunction

    function automatic int unsigned pick_gain();
        case ($urandom_range(0, 3))
            0: return 0;
            1: return GAIN_MAX;
            default: return $urandom_range(1, 16'h0400);
        endcase
    endfunction

    task automatic send_sample(logic signed [MEAS_W-1:0] meas);
        drive_due.push_back(drive_for_sample(meas));
        sample_ch.valid          <= 1'b1;
        sample_ch.measured_value <= meas;
        do @(posedge clk); while (!sample_ch.ready);
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            sample_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
    endtask

    task automatic drain();
        sample_ch.valid <= 1'b0;
        while (drive_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        regs_ch.valid <= 1'b1;
        regs_ch.index <= idx;
        regs_ch.data  <= value;
        do @(posedge clk); while (!regs_ch.ready);
        case (idx)
            REG_SETPOINT: sp_reg   = $signed(value[MEAS_W-1:0]);
            REG_GAIN_P:   kp_reg   = value[GAIN_W-1:0];
            REG_GAIN_I:   ki_reg   = value[GAIN_W-1:0];
            REG_GAIN_D:   kd_reg   = value[GAIN_W-1:0];
            REG_BAND:     band_reg = value[BAND_W-1:0];
            default: ;
        endcase
    endtask

    // wait for an empty pipe, then write every register; junk rides in the
    // upper gain data bits and one write goes to an unmapped index
    task automatic configure(longint sp, int unsigned kp, int unsigned ki,
                             int unsigned kd, int unsigned band);
        drain();
        write_reg(CFG_IDX_W'($urandom_range(int'(REG_BAND) + 1, IDX_TOP)),
                  CFG_DATA_W'($urandom));
        write_reg(REG_SETPOINT, CFG_DATA_W'(sp));
        write_reg(REG_GAIN_P, CFG_DATA_W'({$urandom, kp[GAIN_W-1:0]}));
        write_reg(REG_GAIN_I, CFG_DATA_W'({$urandom, ki[GAIN_W-1:0]}));
        write_reg(REG_GAIN_D, CFG_DATA_W'({$urandom, kd[GAIN_W-1:0]}));
        write_reg(REG_BAND, CFG_DATA_W'(band));
        regs_ch.valid <= 1'b0;
    endtask

    task automatic test_reset_state();
        send_sample(MEAS_W'(MEAS_HI));
        send_sample(MEAS_W'(MEAS_LO));
        send_sample('0);
        send_sample(MEAS_W'(1));
    endtask

    task automatic test_gain_extremes();
        configure(0, 16'h0100, 0, 0, 0);
        send_sample(MEAS_W'(1234));
        send_sample(MEAS_W'(-1));
        send_sample(MEAS_W'(1));
        configure(MEAS_HI, GAIN_MAX, 0, GAIN_MAX, BAND_MAX);
        send_sample(MEAS_W'(MEAS_LO));
        send_sample(MEAS_W'(MEAS_HI));
        configure(MEAS_LO, GAIN_MAX, GAIN_MAX, GAIN_MAX, BAND_MAX);
        send_sample(MEAS_W'(MEAS_HI));
        send_sample(MEAS_W'(MEAS_LO));
        // floor on the fraction drop
        configure(0, 1, 0, 0, 0);
        send_sample(MEAS_W'(1));
        send_sample(MEAS_W'(-1));
    endtask

    task automatic test_integral_rules();
        // zero band: clear on sign change only
        configure(0, 0, 16'h0100, 0, 0);
        send_sample(MEAS_W'(-5));
        send_sample(MEAS_W'(-5));
        send_sample('0);
        send_sample(MEAS_W'(5));
        // band edge: below accumulates, equal does not
        configure(0, 0, 16'h0100, 0, 100);
        send_sample(MEAS_W'(-99));
        send_sample(MEAS_W'(-100));
        send_sample(MEAS_W'(-99));
        send_sample(MEAS_W'(100));
        send_sample(MEAS_W'(99));
        // zero integral gain freezes the sum across sign changes
        configure(0, 0, 0, 0, 100);
        send_sample(MEAS_W'(10));
        send_sample(MEAS_W'(-10));
        configure(0, 0, 16'h0100, 0, 100);
        send_sample(MEAS_W'(-10));
    endtask

    task automatic test_integral_windup();
        configure(MEAS_HI, 0, $urandom_range(1, 16'h0100), 0, BAND_MAX);
        repeat (140)
            send_sample(MEAS_W'(-longint'($urandom_range(8000000, 8388608))));
        configure(MEAS_LO, $urandom_range(0, 3), $urandom_range(1, 16'h0100), 0,
                  BAND_MAX);
        repeat (140)
            send_sample(MEAS_W'(longint'($urandom_range(8000000, 8388607))));
    endtask

    task automatic test_random_settings();
        longint      sp, m;
        int unsigned band, lim;
        for (int phase = 0; phase < 5; phase++)
        begin
            case ($urandom_range(0, 3))
                0: sp = MEAS_LO;
                1: sp = MEAS_HI;
                default: sp = $signed(MEAS_W'($urandom));
            endcase
            case ($urandom_range(0, 4))
                0: band = 0;
                1: band = BAND_MAX;
                default: band = $urandom_range(1, 5000);
            endcase
            configure(sp, pick_gain(), pick_gain(), pick_gain(), band);
            // run the final stretch with no idling on either side
            if (phase == 4)
                quiet = 1'b1;
            lim = (band < 100000) ? band + 2 : 100000;
            repeat (30)
            begin
                case ($urandom_range(0, 9))
                    0: m = $urandom_range(0, 1) ? MEAS_HI : MEAS_LO;
                    1, 2: m = $signed(MEAS_W'($urandom));
                    default: m = sp_reg - (longint'($urandom_range(0, 2 * lim)) - lim);
                endcase
                if (m > MEAS_HI)
                    m = MEAS_HI;
                if (m < MEAS_LO)
                    m = MEAS_LO;
                send_sample(MEAS_W'(m));
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (drive_due.size() == 0)
            begin
                $error("drive word with no sample pending: drive_value %0d saturated %0b",
                       result_ch.drive_value, result_ch.saturated);
                fail_count++;
            end
            else
            begin
                want_word = drive_due.pop_front();
                if (result_ch.drive_value !== want_word.drive_value)
                begin
                    $error("drive_value expected %0d actual %0d",
                           want_word.drive_value, result_ch.drive_value);
                    fail_count++;
                end
                if (result_ch.saturated !== want_word.saturated)
                begin
                    $error("saturated expected %0b actual %0b",
                           want_word.saturated, result_ch.saturated);
                    fail_count++;
                end
            end
        end
    end

    // receiver stalls in bursts
    initial
    begin
        result_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (quiet || $urandom_range(0, 2) != 0)
            begin
                result_ch.ready <= 1'b1;
                repeat ($urandom_range(1, 30)) @(posedge clk);
            end
            else
            begin
                result_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge clk);
            end
        end
    end

    initial
    begin
        rst_n      = 1'b0;
        quiet      = 1'b0;
        fail_count = 0;
        sp_reg     = 0;
        kp_reg     = 0;
        ki_reg     = 0;
        kd_reg     = 0;
        band_reg   = 0;
        last_err   = 0;
        integ      = 0;
        sample_ch.valid          <= 1'b0;
        sample_ch.measured_value <= '0;
        regs_ch.valid            <= 1'b0;
        regs_ch.index            <= '0;
        regs_ch.data             <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_state();
        test_gain_extremes();
        test_integral_rules();
        test_integral_windup();
        test_random_settings();

        drain();
        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("pid_with_banded_integral: match");
        else
            $display("pid_with_banded_integral: mismatch");
        $finish;
    end

endmodule
